// File: rtl/core/psc_pkg.sv
// Shared types and constants for the polyline/sphere collision block.
// Used by the front end, the job queue, the back end and the top level.
package psc_pkg;

    localparam int COORD_W = 32;
    localparam int RAD_W   = 31;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] CFG_SPHERE_X      = 2'd0;
    localparam logic [1:0] CFG_SPHERE_Y      = 2'd1;
    localparam logic [1:0] CFG_SPHERE_Z      = 2'd2;
    localparam logic [1:0] CFG_SPHERE_RADIUS = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic                      end_of_path;
    } in_item_t;

    typedef struct packed {
        logic point_inside;
        logic segment_hit;
        logic path_hit;
        logic path_done;
    } out_item_t;

    // One classified point: offsets from the center for both endpoints,
    // the segment direction, and the path bookkeeping.
    typedef struct packed {
        logic signed [DIFF_W-1:0] px;
        logic signed [DIFF_W-1:0] py;
        logic signed [DIFF_W-1:0] pz;
        logic signed [DIFF_W-1:0] qx;
        logic signed [DIFF_W-1:0] qy;
        logic signed [DIFF_W-1:0] qz;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] dz;
        logic [RAD_W-1:0]         radius;
        logic                     have_prev;
        logic                     last;
    } job_t;

endpackage

// File: rtl/core/psc_queue.sv
// Short job queue between the front end and the back end.
// Depends on psc_pkg for the job type and depth.
module psc_queue
    import psc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output job_t head
);

    job_t                 entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]      count_reg, count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: rtl/core/psc_front.sv
// Front end: accepts points, keeps the previous point of the path and forms
// the center offsets and segment direction. Depends on psc_pkg.
module psc_front
    import psc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  in_item_t                  in_data,
    output logic                      in_stall,
    input  logic                      queue_full,
    input  logic signed [COORD_W-1:0] sphere_x,
    input  logic signed [COORD_W-1:0] sphere_y,
    input  logic signed [COORD_W-1:0] sphere_z,
    input  logic [RAD_W-1:0]          sphere_radius,
    output logic                      push,
    output job_t                      job
);

    logic signed [COORD_W-1:0] prev_x_reg, prev_y_reg, prev_z_reg;
    logic                      have_prev_reg;

    function automatic logic signed [DIFF_W-1:0] sub_ext(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        return {a[COORD_W-1], a} - {b[COORD_W-1], b};
    endfunction

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        job.px        = sub_ext(in_data.point_x, sphere_x);
        job.py        = sub_ext(in_data.point_y, sphere_y);
        job.pz        = sub_ext(in_data.point_z, sphere_z);
        job.qx        = sub_ext(prev_x_reg, sphere_x);
        job.qy        = sub_ext(prev_y_reg, sphere_y);
        job.qz        = sub_ext(prev_z_reg, sphere_z);
        job.dx        = sub_ext(in_data.point_x, prev_x_reg);
        job.dy        = sub_ext(in_data.point_y, prev_y_reg);
        job.dz        = sub_ext(in_data.point_z, prev_z_reg);
        job.radius    = sphere_radius;
        job.have_prev = have_prev_reg;
        job.last      = in_data.end_of_path;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_z_reg    <= '0;
            have_prev_reg <= 1'b0;
        end
        else if (push)
        begin
            prev_x_reg    <= in_data.point_x;
            prev_y_reg    <= in_data.point_y;
            prev_z_reg    <= in_data.point_z;
            have_prev_reg <= !in_data.end_of_path;
        end
    end

endmodule

// File: rtl/core/psc_back.sv
// Back end: runs the distance and foot tests of one job on a single shared
// multiplier, then drives the registered result. Depends on psc_pkg.
module psc_back
    import psc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    input  job_t      job,
    output logic      job_pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam int SQ_W   = 2 * DIFF_W + 2;   // sum of three squares
    localparam int R2_W   = 2 * RAD_W;
    localparam int A_W    = SQ_W + 1;
    localparam int LIMB_W = SQ_W / 2;
    localparam int MUL_W  = LIMB_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int D_W    = 2 * SQ_W + 1;

    // Multiply schedule: point squares, radius, previous point squares,
    // direction squares, dot product, a gap, then the wide cross products.
    localparam logic [4:0] S_R     = 5'd3;
    localparam logic [4:0] S_E     = 5'd4;
    localparam logic [4:0] S_B     = 5'd7;
    localparam logic [4:0] S_A     = 5'd10;
    localparam logic [4:0] S_GAP   = 5'd13;
    localparam logic [4:0] S_MHBH  = 5'd14;
    localparam logic [4:0] S_MHBL  = 5'd15;
    localparam logic [4:0] S_MLBH  = 5'd16;
    localparam logic [4:0] S_MLBL  = 5'd17;
    localparam logic [4:0] S_AHAH  = 5'd18;
    localparam logic [4:0] S_AHAL  = 5'd19;
    localparam logic [4:0] S_ALAL  = 5'd20;
    localparam logic [4:0] S_FLUSH = 5'd21;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

    state_t                   state_reg;
    job_t                     job_reg;
    logic [4:0]               step_reg;
    logic [4:0]               ptag_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [SQ_W-1:0]          acc_p_reg, acc_e_reg, acc_b_reg;
    logic [R2_W-1:0]          r2_reg;
    logic signed [A_W-1:0]    acc_a_reg;
    logic signed [A_W-1:0]    m_reg;
    logic signed [D_W-1:0]    acc_d_reg;
    logic                     hit_reg;
    logic                     out_valid_reg;
    out_item_t                out_data_reg;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic [1:0]               sel;
    logic [D_W-1:0]           term;
    logic                     pin, in1, a_pos, a_lt_b, m_le0, foot, seg, new_hit;
    logic                     load_out;

    function automatic logic signed [MUL_W-1:0] sx(input logic signed [DIFF_W-1:0] v);
        return {{(MUL_W-DIFF_W){v[DIFF_W-1]}}, v};
    endfunction

    function automatic logic signed [MUL_W-1:0] limb(input logic [LIMB_W-1:0] v);
        return {1'b0, v};
    endfunction

    function automatic logic signed [DIFF_W-1:0] pick3(
        input logic [1:0]               s,
        input logic signed [DIFF_W-1:0] x,
        input logic signed [DIFF_W-1:0] y,
        input logic signed [DIFF_W-1:0] z
    );
        logic signed [DIFF_W-1:0] r;
        case (s)
            2'd0:    r = x;
            2'd1:    r = y;
            default: r = z;
        endcase
        return r;
    endfunction

    always_comb
    begin
        sel   = 2'd0;
        mul_a = '0;
        mul_b = '0;
        priority if (step_reg < S_R)
        begin
            sel   = step_reg[1:0];
            mul_a = sx(pick3(sel, job_reg.px, job_reg.py, job_reg.pz));
            mul_b = mul_a;
        end
        else if (step_reg == S_R)
        begin
            mul_a = {{(MUL_W-RAD_W){1'b0}}, job_reg.radius};
            mul_b = mul_a;
        end
        else if (step_reg < S_B)
        begin
            sel   = 2'(step_reg - S_E);
            mul_a = sx(pick3(sel, job_reg.qx, job_reg.qy, job_reg.qz));
            mul_b = mul_a;
        end
        else if (step_reg < S_A)
        begin
            sel   = 2'(step_reg - S_B);
            mul_a = sx(pick3(sel, job_reg.dx, job_reg.dy, job_reg.dz));
            mul_b = mul_a;
        end
        else if (step_reg < S_GAP)
        begin
            sel   = 2'(step_reg - S_A);
            mul_a = sx(pick3(sel, job_reg.dx, job_reg.dy, job_reg.dz));
            mul_b = sx(pick3(sel, job_reg.qx, job_reg.qy, job_reg.qz));
        end
        else if (step_reg == S_MHBH)
        begin
            mul_a = limb(m_reg[SQ_W-1:LIMB_W]);
            mul_b = limb(acc_b_reg[SQ_W-1:LIMB_W]);
        end
        else if (step_reg == S_MHBL)
        begin
            mul_a = limb(m_reg[SQ_W-1:LIMB_W]);
            mul_b = limb(acc_b_reg[LIMB_W-1:0]);
        end
        else if (step_reg == S_MLBH)
        begin
            mul_a = limb(m_reg[LIMB_W-1:0]);
            mul_b = limb(acc_b_reg[SQ_W-1:LIMB_W]);
        end
        else if (step_reg == S_MLBL)
        begin
            mul_a = limb(m_reg[LIMB_W-1:0]);
            mul_b = limb(acc_b_reg[LIMB_W-1:0]);
        end
        else if (step_reg == S_AHAH)
        begin
            mul_a = limb(acc_a_reg[SQ_W-1:LIMB_W]);
            mul_b = mul_a;
        end
        else if (step_reg == S_AHAL)
        begin
            mul_a = limb(acc_a_reg[SQ_W-1:LIMB_W]);
            mul_b = limb(acc_a_reg[LIMB_W-1:0]);
        end
        else if (step_reg == S_ALAL)
        begin
            mul_a = limb(acc_a_reg[LIMB_W-1:0]);
            mul_b = mul_a;
        end
        else
        begin
            mul_a = '0;
            mul_b = '0;
        end
    end

    assign term = {{(D_W-SQ_W){1'b0}}, prod_reg[SQ_W-1:0]};

    // The foot test is 0 < a < b and (e2 <= r2 or (e2 - r2) * b < a^2),
    // with (e2 - r2) * b - a^2 from 34-bit limbs in one signed accumulator.
    always_comb
    begin
        pin     = acc_p_reg < {{(SQ_W-R2_W){1'b0}}, r2_reg};
        in1     = acc_e_reg < {{(SQ_W-R2_W){1'b0}}, r2_reg};
        a_pos   = !acc_a_reg[A_W-1] && (acc_a_reg != '0);
        a_lt_b  = acc_a_reg < $signed({1'b0, acc_b_reg});
        m_le0   = m_reg[A_W-1] || (m_reg == '0);
        foot    = a_pos && a_lt_b && (m_le0 || acc_d_reg[D_W-1]);
        seg     = job_reg.have_prev && (pin || in1 || foot);
        new_hit = hit_reg || seg;
    end

    assign job_pop   = (state_reg == ST_IDLE) && job_valid;
    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            ptag_reg      <= S_GAP;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !load_out)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    ptag_reg <= S_GAP;
                    if (job_valid)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    ptag_reg <= step_reg;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == S_FLUSH)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    ptag_reg <= S_GAP;
                    if (load_out)
                    begin
                        out_valid_reg             <= 1'b1;
                        out_data_reg.point_inside <= pin;
                        out_data_reg.segment_hit  <= seg;
                        out_data_reg.path_hit     <= new_hit;
                        out_data_reg.path_done    <= job_reg.last;
                        hit_reg                   <= job_reg.last ? 1'b0 : new_hit;
                        state_reg                 <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (job_pop)
        begin
            job_reg   <= job;
            acc_p_reg <= '0;
            acc_e_reg <= '0;
            acc_b_reg <= '0;
            acc_a_reg <= '0;
            acc_d_reg <= '0;
        end
        else
        begin
            priority if (ptag_reg < S_R)
            begin
                acc_p_reg <= acc_p_reg + prod_reg[SQ_W-1:0];
            end
            else if (ptag_reg == S_R)
            begin
                r2_reg <= prod_reg[R2_W-1:0];
            end
            else if (ptag_reg < S_B)
            begin
                acc_e_reg <= acc_e_reg + prod_reg[SQ_W-1:0];
            end
            else if (ptag_reg < S_A)
            begin
                acc_b_reg <= acc_b_reg + prod_reg[SQ_W-1:0];
            end
            else if (ptag_reg < S_GAP)
            begin
                // a = dot(d, c - p1) = -dot(d, p1 - c)
                acc_a_reg <= acc_a_reg - $signed(prod_reg[A_W-1:0]);
            end
            else if (ptag_reg == S_MHBH)
            begin
                acc_d_reg <= acc_d_reg + $signed(term << (2 * LIMB_W));
            end
            else if (ptag_reg == S_MHBL || ptag_reg == S_MLBH)
            begin
                acc_d_reg <= acc_d_reg + $signed(term << LIMB_W);
            end
            else if (ptag_reg == S_MLBL)
            begin
                acc_d_reg <= acc_d_reg + $signed(term);
            end
            else if (ptag_reg == S_AHAH)
            begin
                acc_d_reg <= acc_d_reg - $signed(term << (2 * LIMB_W));
            end
            else if (ptag_reg == S_AHAL)
            begin
                acc_d_reg <= acc_d_reg - $signed(term << (LIMB_W + 1));
            end
            else if (ptag_reg == S_ALAL)
            begin
                acc_d_reg <= acc_d_reg - $signed(term);
            end
            else
            begin
                acc_d_reg <= acc_d_reg;
            end
        end
        if (state_reg == ST_RUN && step_reg == S_GAP)
        begin
            m_reg <= $signed({1'b0, acc_e_reg}) - $signed({{(A_W-R2_W){1'b0}}, r2_reg});
        end
    end

endmodule

// File: rtl/core/polyline_sphere_collision.sv
// Polyline against sphere collision test, one result per point.
// The back end takes one item at a time: the single 35x35 multiplier forms
// 20 products per item, and the next item is popped only after the result
// register is loaded, which an output stall can hold off. A two-entry queue
// lets the front accept while the back works. Reset clears the sphere
// registers, the path state, the queue and the result register.
module polyline_sphere_collision
    import psc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data,
    input  logic             cfg_write,
    input  logic [1:0]       cfg_index,
    input  logic [COORD_W-1:0] cfg_data
);

    logic signed [COORD_W-1:0] sphere_x_reg, sphere_y_reg, sphere_z_reg;
    logic [RAD_W-1:0]          sphere_radius_reg;
    logic                      queue_full, queue_not_empty, push, pop;
    job_t                      front_job, head_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sphere_x_reg      <= '0;
            sphere_y_reg      <= '0;
            sphere_z_reg      <= '0;
            sphere_radius_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SPHERE_X:      sphere_x_reg      <= cfg_data;
                CFG_SPHERE_Y:      sphere_y_reg      <= cfg_data;
                CFG_SPHERE_Z:      sphere_z_reg      <= cfg_data;
                CFG_SPHERE_RADIUS: sphere_radius_reg <= cfg_data[RAD_W-1:0];
                default:           sphere_x_reg      <= sphere_x_reg;
            endcase
        end
    end

    psc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_data       (in_data),
        .in_stall      (in_stall),
        .queue_full    (queue_full),
        .sphere_x      (sphere_x_reg),
        .sphere_y      (sphere_y_reg),
        .sphere_z      (sphere_z_reg),
        .sphere_radius (sphere_radius_reg),
        .push          (push),
        .job           (front_job)
    );

    psc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (front_job),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (head_job)
    );

    psc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (queue_not_empty),
        .job       (head_job),
        .job_pop   (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// File: rtl/core/psc_checker.sv
// Port-level checks for the polyline/sphere collision block, bound to the
// top level. Depends on psc_pkg for the item types.
module psc_checker
    import psc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input out_item_t          out_data,
    input logic               cfg_write,
    input logic [1:0]         cfg_index,
    input logic [COORD_W-1:0] cfg_data
);

    // Tracks whether the radius register holds zero; reset leaves it zero.
    logic radius_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_zero_reg <= 1'b1;
        end
        else if (cfg_write && cfg_index == CFG_SPHERE_RADIUS)
        begin
            radius_zero_reg <= (cfg_data[RAD_W-1:0] == '0);
        end
    end

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_seg_sets_path: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.segment_hit |-> out_data.path_hit)
        else $error("segment hit without path hit");

    a_zero_radius: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && radius_zero_reg |-> !out_data.point_inside && !out_data.segment_hit)
        else $error("hit reported with zero radius");

endmodule

bind polyline_sphere_collision psc_checker u_psc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);
